// ===== hdl/gic_pkg.sv =====
// ----------------------------------------------------------------------------
// gic_pkg
// Shared types and constants of the gamepad input conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package gic_pkg;

  // classified request handed from the front end to the vector unit
  typedef struct packed {
    logic       stick;
    logic       neg_x;
    logic       neg_y;
    logic [7:0] ax;
    logic [7:0] ay;
    logic       held;
    logic       attack_edge;
    logic       up_edge;
    logic       down_edge;
    logic       select_edge;
  } gic_entry_t;

  localparam logic [6:0]        DEAD_ZONE_RST = 7'd15;
  localparam logic signed [7:0] MENU_HI       = 8'sd50;
  localparam logic signed [7:0] MENU_LO       = -8'sd50;
  localparam logic [6:0]        STICK_UNIT    = 7'd100;
  localparam logic [6:0]        KEY_UNIT      = 7'd1;
  localparam logic [15:0]       STICK_UNIT_SQ = 16'd10000;
  localparam logic [15:0]       KEY_UNIT_SQ   = 16'd1;

endpackage

`default_nettype wire

// ===== hdl/gic_front.sv =====
// ----------------------------------------------------------------------------
// gic_front
// Accepts samples, applies the dead zone, forms menu and attack edges.
// ----------------------------------------------------------------------------
`default_nettype none

module gic_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [6:0]        cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_stick_present,
  input  wire logic [7:0]        in_axis_x,
  input  wire logic [7:0]        in_axis_y,
  input  wire logic              in_button_a,
  input  wire logic              in_key_up,
  input  wire logic              in_key_down,
  input  wire logic              in_key_enter,
  input  wire logic              in_key_north,
  input  wire logic              in_key_south,
  input  wire logic              in_key_west,
  input  wire logic              in_key_east,
  input  wire logic              in_key_space,
  input  wire logic              q_full,
  output logic                   q_push,
  output gic_pkg::gic_entry_t    q_din
);

  logic [6:0] dead_zone_r;
  logic       last_up_r;
  logic       last_down_r;
  logic       last_select_r;
  logic       last_attack_r;

  logic       accept;
  logic       up_now;
  logic       down_now;
  logic       sel_now;
  logic       attack_nxt;
  logic [7:0] abs_x;
  logic [7:0] abs_y;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  assign abs_x = in_axis_x[7] ? 8'(-in_axis_x) : in_axis_x;
  assign abs_y = in_axis_y[7] ? 8'(-in_axis_y) : in_axis_y;

  always_comb begin
    q_din = '0;
    q_din.stick = in_stick_present;
    if (in_stick_present) begin
      up_now     = $signed(in_axis_y) < gic_pkg::MENU_LO;
      down_now   = $signed(in_axis_y) > gic_pkg::MENU_HI;
      sel_now    = in_button_a;
      attack_nxt = in_button_a;
      q_din.held        = in_button_a;
      q_din.attack_edge = in_button_a && !last_attack_r;
      q_din.neg_x       = in_axis_x[7];
      q_din.neg_y       = in_axis_y[7];
      q_din.ax          = (abs_x < {1'b0, dead_zone_r}) ? 8'd0 : abs_x;
      q_din.ay          = (abs_y < {1'b0, dead_zone_r}) ? 8'd0 : abs_y;
    end else begin
      up_now     = in_key_up;
      down_now   = in_key_down;
      sel_now    = in_key_enter;
      attack_nxt = 1'b0;
      q_din.held        = in_key_space;
      q_din.attack_edge = 1'b0;
      q_din.neg_x       = in_key_west && !in_key_east;
      q_din.neg_y       = in_key_north && !in_key_south;
      q_din.ax          = {7'd0, in_key_west ^ in_key_east};
      q_din.ay          = {7'd0, in_key_north ^ in_key_south};
    end
    q_din.up_edge     = up_now && !last_up_r;
    q_din.down_edge   = down_now && !last_down_r;
    q_din.select_edge = sel_now && !last_select_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r   <= gic_pkg::DEAD_ZONE_RST;
      last_up_r     <= 1'b0;
      last_down_r   <= 1'b0;
      last_select_r <= 1'b0;
      last_attack_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        dead_zone_r <= cfg_wdata;
      end
      if (accept) begin
        last_up_r     <= up_now;
        last_down_r   <= down_now;
        last_select_r <= sel_now;
        last_attack_r <= attack_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gic_fifo.sv =====
// ----------------------------------------------------------------------------
// gic_fifo
// Two-entry request queue between the front end and the vector unit.
// ----------------------------------------------------------------------------
`default_nettype none

module gic_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire gic_pkg::gic_entry_t din,
  output logic                   full,
  input  wire logic              pop,
  output logic                   empty,
  output gic_pkg::gic_entry_t    dout
);

  gic_pkg::gic_entry_t slot0_r;
  gic_pkg::gic_entry_t slot1_r;
  logic                v0_r;
  logic                v1_r;

  assign full  = v1_r;
  assign empty = !v0_r;
  assign dout  = slot0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      if (pop) begin
        if (v1_r) begin
          v1_r <= 1'b0;
        end else begin
          v0_r <= push;
        end
      end else if (push) begin
        if (v0_r) begin
          v1_r <= 1'b1;
        end else begin
          v0_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (v1_r) begin
        slot0_r <= slot1_r;
      end else if (push) begin
        slot0_r <= din;
      end
    end else if (push) begin
      if (v0_r) begin
        slot1_r <= din;
      end else begin
        slot0_r <= din;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gic_back.sv =====
// ----------------------------------------------------------------------------
// gic_back
// Vector unit: scaling, iterative square root, two restoring dividers,
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gic_back #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire gic_pkg::gic_entry_t q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_stick_mode,
  output logic [15:0]            out_move_x,
  output logic [15:0]            out_move_y,
  output logic                   out_attack_held,
  output logic                   out_attack_edge,
  output logic                   out_menu_up_edge,
  output logic                   out_menu_down_edge,
  output logic                   out_menu_select_edge
);

  localparam int RT_W  = 8 + FRAC_BITS;
  localparam int N_W   = 2 * RT_W;
  localparam int D_W   = RT_W + FRAC_BITS;
  localparam int NUM_W = 9 + 2 * FRAC_BITS;
  localparam int Q_W   = FRAC_BITS + 1;
  localparam int MW    = (FRAC_BITS + 2 > 16) ? FRAC_BITS + 2 : 16;
  localparam int CNT_W = $clog2(RT_W + 1);

  localparam logic [Q_W-1:0] ONE = Q_W'(1) << FRAC_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQRT = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]          state_r;
  logic [CNT_W-1:0]    cnt_r;
  gic_pkg::gic_entry_t item_r;
  logic                long_r;
  logic [N_W-1:0]      n_r;
  logic [RT_W-1:0]     root_r;
  logic [RT_W+1:0]     rem_r;
  logic [RT_W-1:0]     den_r;
  logic [NUM_W-1:0]    rx_r;
  logic [NUM_W-1:0]    ry_r;
  logic [D_W-1:0]      d_r;
  logic [Q_W-1:0]      qx_r;
  logic [Q_W-1:0]      qy_r;
  logic                out_valid_r;
  logic                stick_r;
  logic [15:0]         move_x_r;
  logic [15:0]         move_y_r;
  logic                held_r;
  logic                atk_edge_r;
  logic                up_edge_r;
  logic                down_edge_r;
  logic                sel_edge_r;

  logic [15:0]         sq_x;
  logic [15:0]         sq_y;
  logic [15:0]         s_sum;
  logic [15:0]         unit_sq;
  logic                is_long;
  logic [RT_W+1:0]     rem_t;
  logic [RT_W+1:0]     trial;
  logic                rem_ge;
  logic [RT_W+1:0]     rem_nxt;
  logic [RT_W-1:0]     root_nxt;
  logic                rx_ge;
  logic                ry_ge;
  logic [NUM_W-1:0]    rx_nxt;
  logic [NUM_W-1:0]    ry_nxt;
  logic [NUM_W-1:0]    half_den;
  logic [NUM_W-1:0]    num_x;
  logic [NUM_W-1:0]    num_y;
  logic [Q_W-1:0]      mag_x;
  logic [Q_W-1:0]      mag_y;
  logic                load_out;

  function automatic logic [15:0] signed_mag(input logic neg, input logic [Q_W-1:0] mag);
    logic [MW-1:0] ext;
    ext = MW'(mag);
    if (neg) begin
      ext = MW'(-ext);
    end
    return ext[15:0];
  endfunction

  // vector length test on the queue head
  assign sq_x    = q_head.ax * q_head.ax;
  assign sq_y    = q_head.ay * q_head.ay;
  assign s_sum   = sq_x + sq_y;
  assign unit_sq = q_head.stick ? gic_pkg::STICK_UNIT_SQ : gic_pkg::KEY_UNIT_SQ;
  assign is_long = s_sum > unit_sq;

  assign q_pop = (state_r == ST_IDLE) && !q_empty;

  // one root bit per cycle
  assign rem_t    = {rem_r[RT_W-1:0], n_r[N_W-1 -: 2]};
  assign trial    = {root_r, 2'b01};
  assign rem_ge   = rem_t >= trial;
  assign rem_nxt  = rem_ge ? rem_t - trial : rem_t;
  assign root_nxt = {root_r[RT_W-2:0], rem_ge};

  // one quotient bit per cycle on each axis
  assign rx_ge  = rx_r >= NUM_W'(d_r);
  assign ry_ge  = ry_r >= NUM_W'(d_r);
  assign rx_nxt = rx_ge ? rx_r - NUM_W'(d_r) : rx_r;
  assign ry_nxt = ry_ge ? ry_r - NUM_W'(d_r) : ry_r;

  assign half_den = NUM_W'(den_r >> 1);
  assign num_x    = long_r ? NUM_W'(item_r.ax) << (2 * FRAC_BITS)
                           : NUM_W'(item_r.ax) << FRAC_BITS;
  assign num_y    = long_r ? NUM_W'(item_r.ay) << (2 * FRAC_BITS)
                           : NUM_W'(item_r.ay) << FRAC_BITS;

  assign mag_x    = (qx_r > ONE) ? ONE : qx_r;
  assign mag_y    = (qy_r > ONE) ? ONE : qy_r;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            state_r <= is_long ? ST_SQRT : ST_PREP;
          end
        end
        ST_SQRT: begin
          if (cnt_r == CNT_W'(RT_W - 1)) begin
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt_r == CNT_W'(FRAC_BITS)) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        item_r <= q_head;
        long_r <= is_long;
        cnt_r  <= '0;
        n_r    <= {s_sum, (N_W - 16)'(0)};
        root_r <= '0;
        rem_r  <= '0;
        den_r  <= RT_W'(q_head.stick ? gic_pkg::STICK_UNIT : gic_pkg::KEY_UNIT);
      end
      ST_SQRT: begin
        n_r    <= n_r << 2;
        root_r <= root_nxt;
        rem_r  <= rem_nxt;
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(RT_W - 1)) begin
          den_r <= root_nxt;
        end
      end
      ST_PREP: begin
        rx_r  <= num_x + half_den;
        ry_r  <= num_y + half_den;
        d_r   <= D_W'(den_r) << FRAC_BITS;
        qx_r  <= '0;
        qy_r  <= '0;
        cnt_r <= '0;
      end
      ST_DIV: begin
        rx_r  <= rx_nxt;
        ry_r  <= ry_nxt;
        qx_r  <= {qx_r[Q_W-2:0], rx_ge};
        qy_r  <= {qy_r[Q_W-2:0], ry_ge};
        d_r   <= d_r >> 1;
        cnt_r <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      stick_r     <= item_r.stick;
      move_x_r    <= signed_mag(item_r.neg_x, mag_x);
      move_y_r    <= signed_mag(item_r.neg_y, mag_y);
      held_r      <= item_r.held;
      atk_edge_r  <= item_r.attack_edge;
      up_edge_r   <= item_r.up_edge;
      down_edge_r <= item_r.down_edge;
      sel_edge_r  <= item_r.select_edge;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_stick_mode       = stick_r;
  assign out_move_x           = move_x_r;
  assign out_move_y           = move_y_r;
  assign out_attack_held      = held_r;
  assign out_attack_edge      = atk_edge_r;
  assign out_menu_up_edge     = up_edge_r;
  assign out_menu_down_edge   = down_edge_r;
  assign out_menu_select_edge = sel_edge_r;

endmodule

`default_nettype wire

// ===== hdl/gamepad_input_conditioner_top.sv =====
// ----------------------------------------------------------------------------
// gamepad_input_conditioner_top
// Per-frame stick or keyboard sample to movement vector and menu/attack edges.
// ----------------------------------------------------------------------------
// Input channel (in_*): one sample per request, taken when in_valid is high
// and in_stall is low. Output channel (out_*): one result per request, held
// while out_stall is high. cfg_we/cfg_wdata write the dead zone register.
// The front end classifies each sample in the cycle it is taken and updates
// the edge history, then queues it in a two-entry queue, so it keeps taking
// samples while the vector unit works or the output is stalled, until the
// queue is full. The vector unit handles one request at a time: it runs
// the square root loop (one root bit a cycle) only when the vector lies
// outside the unit circle and must be normalized, then the two dividers
// (one quotient bit a cycle). With the unit idle, an accepted sample is
// registered in the queue, popped in the idle state, and passes through
// the square root (if needed), prep, divide and done states before the
// output register raises out_valid; a finished result waits in the output
// register while the next request is already being worked on.
// Reset (rst_n, synchronous) clears the queue, the edge history and the
// output valid, and sets the dead zone to 15.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_input_conditioner_top #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_stick_present,
  input  wire logic [7:0]  in_axis_x,
  input  wire logic [7:0]  in_axis_y,
  input  wire logic        in_button_a,
  input  wire logic        in_key_up,
  input  wire logic        in_key_down,
  input  wire logic        in_key_enter,
  input  wire logic        in_key_north,
  input  wire logic        in_key_south,
  input  wire logic        in_key_west,
  input  wire logic        in_key_east,
  input  wire logic        in_key_space,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_stick_mode,
  output logic [15:0]      out_move_x,
  output logic [15:0]      out_move_y,
  output logic             out_attack_held,
  output logic             out_attack_edge,
  output logic             out_menu_up_edge,
  output logic             out_menu_down_edge,
  output logic             out_menu_select_edge
);

  gic_pkg::gic_entry_t q_din;
  gic_pkg::gic_entry_t q_head;
  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;

  gic_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stick_present (in_stick_present),
    .in_axis_x        (in_axis_x),
    .in_axis_y        (in_axis_y),
    .in_button_a      (in_button_a),
    .in_key_up        (in_key_up),
    .in_key_down      (in_key_down),
    .in_key_enter     (in_key_enter),
    .in_key_north     (in_key_north),
    .in_key_south     (in_key_south),
    .in_key_west      (in_key_west),
    .in_key_east      (in_key_east),
    .in_key_space     (in_key_space),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_din            (q_din)
  );

  gic_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_head)
  );

  gic_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_empty              (q_empty),
    .q_head               (q_head),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_stick_mode       (out_stick_mode),
    .out_move_x           (out_move_x),
    .out_move_y           (out_move_y),
    .out_attack_held      (out_attack_held),
    .out_attack_edge      (out_attack_edge),
    .out_menu_up_edge     (out_menu_up_edge),
    .out_menu_down_edge   (out_menu_down_edge),
    .out_menu_select_edge (out_menu_select_edge)
  );

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue pushed while full");

  a_key_no_attack_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stick_mode) |-> !out_attack_edge)
    else $error("attack edge in keyboard mode");

  a_stick_menu_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stick_mode) |-> !(out_menu_up_edge && out_menu_down_edge))
    else $error("menu up and down together in stick mode");

endmodule

`default_nettype wire
